// ----- hdl/efr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the encoder frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

   localparam int FRAME_LEN = 11;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam int BYTE_W    = 8;
   localparam int OFF_W     = 4;
   localparam int WORD_W    = 32;
   localparam int ERR_W     = 16;
   localparam int LIMIT_W   = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_BYTE2 = 8'h03;

   localparam logic [LIMIT_W-1:0]   ERROR_LIMIT_RESET    = 8'd5;
   localparam logic [CSR_DAT_W-1:0] RECOVERY_TICKS_RESET = 16'd100;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_TICKS = 1'd1;

   typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_type;

   typedef struct packed {
      logic             good;
      logic [IDX_W-1:0] offset;
      logic             now_stopped;
      frame_type        bytes;
   } frame_entry_type;

endpackage

// ----- hdl/efr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_front
// Takes in items, fills the frame, finds the header and keeps error state.
// ----------------------------------------------------------------------------
module efr_front import efr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  logic                 q_full,
   output logic                 q_push,
   output frame_entry_type      q_entry
);

   logic [IDX_W-1:0]     fill_ff, fill_in;
   logic [ERR_W-1:0]     err_ff, err_in;
   logic                 stopped_ff, stopped_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [CSR_DAT_W-1:0] ticks_ff;
   frame_type            frame_ff;
   frame_type            frame_cur;
   logic [FRAME_LEN-1:0] match;
   logic                 found;
   logic [IDX_W-1:0]     found_off;
   logic [ERR_W-1:0]     err_next;
   logic [ERR_W-1:0]     err_dec;
   logic                 over;
   logic                 accept;
   logic                 take_byte;
   logic                 last_byte;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign take_byte = accept && (req_command == CMD_BYTE) && !stopped_ff;
   assign last_byte = (fill_ff == IDX_W'(FRAME_LEN - 1));

   always_comb begin
      frame_cur          = frame_ff;
      frame_cur[fill_ff] = req_rx_byte;
   end

   for (genvar r = 0; r < FRAME_LEN; r++) begin : g_match
      localparam int P1 = (r + 1) % FRAME_LEN;
      localparam int P2 = (r + 2) % FRAME_LEN;
      assign match[r] = (frame_cur[r] == HDR_BYTE0) && (frame_cur[P1] == HDR_BYTE1) &&
                        (frame_cur[P2] == HDR_BYTE2);
   end

   always_comb begin
      found     = 1'b0;
      found_off = '0;
      for (int r = FRAME_LEN - 1; r >= 0; r--) begin
         if (match[r]) begin
            found     = 1'b1;
            found_off = IDX_W'(r);
         end
      end
   end

   assign err_next = (found ? '0 : err_ff) + ERR_W'(1);
   assign over     = err_next > ERR_W'(limit_ff);
   assign err_dec  = (err_ff == '0) ? '0 : err_ff - ERR_W'(1);

   assign q_push              = take_byte && last_byte;
   assign q_entry.good        = found;
   assign q_entry.offset      = found_off;
   assign q_entry.now_stopped = over;
   assign q_entry.bytes       = frame_cur;

   always_comb begin
      fill_in    = fill_ff;
      err_in     = err_ff;
      stopped_in = stopped_ff;
      if (accept && (req_command == CMD_TICK) && stopped_ff) begin
         err_in = err_dec;
         if (err_dec == '0) begin
            stopped_in = 1'b0;
            fill_in    = '0;
         end
      end else if (take_byte) begin
         if (last_byte) begin
            fill_in    = '0;
            err_in     = over ? ERR_W'(ticks_ff) : err_next;
            stopped_in = over;
         end else begin
            fill_in = fill_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         err_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         err_ff     <= err_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ERROR_LIMIT_RESET;
         ticks_ff <= RECOVERY_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ERROR_LIMIT:    limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_RECOVERY_TICKS: ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take_byte) begin
         frame_ff[fill_ff] <= req_rx_byte;
      end
   end

endmodule

// ----- hdl/efr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_queue
// Short FIFO of completed frames between the front and back parts.
// ----------------------------------------------------------------------------
module efr_queue import efr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  frame_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output frame_entry_type head_entry
);

   frame_entry_type      mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff;

   assign full       = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + Q_CNT_W'(1);
            2'b01:   count_ff <= count_ff - Q_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/efr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_back
// Extracts the encoder counts at the header rotation into the result register.
// ----------------------------------------------------------------------------
module efr_back import efr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  frame_entry_type   q_entry,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_frame_good,
   output logic [OFF_W-1:0]  rsp_header_offset,
   output logic [WORD_W-1:0] rsp_left_count,
   output logic [WORD_W-1:0] rsp_right_count,
   output logic              rsp_now_stopped
);

   logic [FRAME_LEN-1:0][WORD_W-1:0] left_cand, right_cand;
   logic [WORD_W-1:0]                left_sel, right_sel;
   logic                             valid_ff;
   logic                             good_ff;
   logic [OFF_W-1:0]                 off_ff;
   logic [WORD_W-1:0]                left_ff, right_ff;
   logic                             stop_ff;

   for (genvar r = 0; r < FRAME_LEN; r++) begin : g_rot
      localparam int L0 = (r + 3) % FRAME_LEN;
      localparam int L1 = (r + 4) % FRAME_LEN;
      localparam int L2 = (r + 5) % FRAME_LEN;
      localparam int L3 = (r + 6) % FRAME_LEN;
      localparam int R0 = (r + 7) % FRAME_LEN;
      localparam int R1 = (r + 8) % FRAME_LEN;
      localparam int R2 = (r + 9) % FRAME_LEN;
      localparam int R3 = (r + 10) % FRAME_LEN;
      assign left_cand[r]  = {q_entry.bytes[L0], q_entry.bytes[L1],
                              q_entry.bytes[L2], q_entry.bytes[L3]};
      assign right_cand[r] = {q_entry.bytes[R0], q_entry.bytes[R1],
                              q_entry.bytes[R2], q_entry.bytes[R3]};
   end

   always_comb begin
      left_sel  = '0;
      right_sel = '0;
      for (int r = 0; r < FRAME_LEN; r++) begin
         if (q_entry.good && (q_entry.offset == IDX_W'(r))) begin
            left_sel  = left_cand[r];
            right_sel = right_cand[r];
         end
      end
   end

   assign q_pop = q_valid && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         good_ff  <= q_entry.good;
         off_ff   <= q_entry.good ? OFF_W'(q_entry.offset) : '0;
         left_ff  <= left_sel;
         right_ff <= right_sel;
         stop_ff  <= q_entry.now_stopped;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_good    = good_ff;
   assign rsp_header_offset = off_ff;
   assign rsp_left_count    = left_ff;
   assign rsp_right_count   = right_ff;
   assign rsp_now_stopped   = stop_ff;

endmodule

// ----- hdl/encoder_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_frame_receiver_top
// Path: a completed frame is written into the frame queue and from there into
// the result register, where rsp_valid turns high.
// Throughput: one item per cycle while the queue has room; the two-entry frame
// queue and result register set how long the input holds under output stall.
// Reset: synchronous, active high; empties the frame, clears the error count,
// the stopped flag and the queue, and loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_frame_receiver_top import efr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_frame_good,
   output logic [OFF_W-1:0]     rsp_header_offset,
   output logic [WORD_W-1:0]    rsp_left_count,
   output logic [WORD_W-1:0]    rsp_right_count,
   output logic                 rsp_now_stopped,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_valid;
   frame_entry_type push_entry;
   frame_entry_type head_entry;

   assign csr_ready = 1'b1;

   efr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_rx_byte (req_rx_byte),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   efr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   efr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (head_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_header_offset (rsp_header_offset),
      .rsp_left_count    (rsp_left_count),
      .rsp_right_count   (rsp_right_count),
      .rsp_now_stopped   (rsp_now_stopped)
   );

endmodule

// ----- hdl/efr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_checker
// Port-level checks on the encoder frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module efr_checker import efr_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_frame_good,
   input logic [OFF_W-1:0]     rsp_header_offset,
   input logic [WORD_W-1:0]    rsp_left_count,
   input logic [WORD_W-1:0]    rsp_right_count,
   input logic                 rsp_now_stopped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_good) &&
      $stable(rsp_header_offset) && $stable(rsp_left_count) &&
      $stable(rsp_right_count) && $stable(rsp_now_stopped))
      else $error("result item changed while stalled");

   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_good |->
      (rsp_header_offset == '0) && (rsp_left_count == '0) && (rsp_right_count == '0))
      else $error("bad frame carries nonzero fields");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_good |-> rsp_header_offset <= OFF_W'(FRAME_LEN - 1))
      else $error("header offset beyond frame");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind encoder_frame_receiver_top efr_checker u_efr_checker (.*);
